// File: rtl/sse_pkg.sv
// Shared types and byte constants for the SQL string escaper.
package sse_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SUB   = 8'h1A;
	localparam logic [7:0] CH_DQUOT = 8'h22;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_USCR  = 8'h5F;
	localparam logic [7:0] CH_LN    = 8'h6E;
	localparam logic [7:0] CH_LR    = 8'h72;

	// Register indexes on the configuration port
	localparam logic REG_QUOTE_DOUBLING = 1'b0;
	localparam logic REG_LIKE_PATTERN   = 1'b1;

	// One queued job: optional doubled backslash, then up to two body bytes
	typedef struct packed {
		logic       pre;
		logic [1:0] cnt;
		logic [7:0] b0;
		logic [7:0] b1;
		logic       last;
	} sse_entry_t;

endpackage

// File: rtl/sse_front.sv
// Front end: accepts input bytes, tracks the held backslash, builds queue entries.
module sse_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	input  logic                quote_doubling_mode,
	input  logic                like_pattern_mode,
	input  logic                q_full,
	output logic                push,
	output sse_pkg::sse_entry_t push_entry
);

	logic held_q;
	logic held_d;
	logic accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		push_entry      = '0;
		push_entry.last = in_last;
		held_d          = 1'b0;
		if (held_q && like_pattern_mode &&
			(in_byte == sse_pkg::CH_PCT || in_byte == sse_pkg::CH_USCR)) begin
			push_entry.cnt = 2'd2;
			push_entry.b0  = sse_pkg::CH_BSL;
			push_entry.b1  = in_byte;
		end else begin
			push_entry.pre = held_q;
			unique case (in_byte) inside
				sse_pkg::CH_APOS: begin
					push_entry.cnt = 2'd2;
					push_entry.b0  = quote_doubling_mode ? sse_pkg::CH_APOS : sse_pkg::CH_BSL;
					push_entry.b1  = sse_pkg::CH_APOS;
				end
				sse_pkg::CH_DQUOT: begin
					push_entry.cnt = 2'd2;
					push_entry.b0  = sse_pkg::CH_BSL;
					push_entry.b1  = sse_pkg::CH_DQUOT;
				end
				sse_pkg::CH_CR, sse_pkg::CH_LF, sse_pkg::CH_SUB: begin
					if (quote_doubling_mode) begin
						push_entry.cnt = 2'd1;
						push_entry.b0  = in_byte;
					end else begin
						push_entry.cnt = 2'd2;
						push_entry.b0  = sse_pkg::CH_BSL;
						push_entry.b1  = (in_byte == sse_pkg::CH_CR) ? sse_pkg::CH_LR :
							(in_byte == sse_pkg::CH_LF) ? sse_pkg::CH_LN : sse_pkg::CH_UZ;
					end
				end
				sse_pkg::CH_NUL: begin
					push_entry.cnt = 2'd2;
					push_entry.b0  = sse_pkg::CH_BSL;
					push_entry.b1  = sse_pkg::CH_ZERO;
				end
				sse_pkg::CH_BSL: begin
					if (like_pattern_mode && !in_last) begin
						held_d = 1'b1;
					end else begin
						push_entry.cnt = 2'd2;
						push_entry.b0  = sse_pkg::CH_BSL;
						push_entry.b1  = sse_pkg::CH_BSL;
					end
				end
				default: begin
					push_entry.cnt = 2'd1;
					push_entry.b0  = in_byte;
				end
			endcase
		end
	end

	assign push = accept && (push_entry.pre || push_entry.cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
		end else if (accept) begin
			held_q <= held_d;
		end
	end

`ifndef SYNTH
	// A backslash is only held right after one was taken in
	a_held_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(held_q) |-> $past(accept && in_byte == sse_pkg::CH_BSL && !in_last))
		else $error("held backslash without backslash input");
	// An accepted byte either produces output or starts a hold
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !push |-> held_d)
		else $error("input byte dropped");
`endif

endmodule

// File: rtl/sse_queue.sv
// Small FIFO of escape jobs between front and back end.
module sse_queue #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sse_pkg::sse_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output sse_pkg::sse_entry_t head,
	output logic                empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sse_pkg::sse_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= bump(wr_ptr_q);
			if (pop)  rd_ptr_q <= bump(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue underflow");
`endif

endmodule

// File: rtl/sse_back.sv
// Back end: serializes queued jobs one byte per cycle into the output register, unless out_stall holds it.
module sse_back (
	input  logic                clk,
	input  logic                arst_n,
	input  sse_pkg::sse_entry_t head,
	input  logic                empty,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          out_byte,
	output logic                out_last
);

	logic [1:0] pos_q;
	logic       load;
	logic [1:0] end_pos;
	logic       at_end;
	logic [7:0] sel_byte;

	assign load    = (!out_valid || !out_stall) && !empty;
	// index of the final byte of the current job
	assign end_pos = head.pre ? (2'd1 + head.cnt) : (head.cnt - 2'd1);
	assign at_end  = (pos_q == end_pos);
	assign pop     = load && at_end;

	always_comb begin
		if (head.pre && !pos_q[1]) begin
			sel_byte = sse_pkg::CH_BSL;
		end else begin
			sel_byte = pos_q[0] ? head.b1 : head.b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 2'd0;
			out_valid <= 1'b0;
		end else begin
			if (load) begin
				pos_q     <= at_end ? 2'd0 : pos_q + 2'd1;
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte <= sel_byte;
			out_last <= head.last && at_end;
		end
	end

`ifndef SYNTH
	// Mid-job position means the job is still at the queue head
	a_pos_live: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != 2'd0 |-> !empty)
		else $error("job position set with empty queue");
`endif

endmodule

// File: rtl/sql_string_escaper.sv
// Top level of the SQL string escaper: config registers, front, queue, back.
//
// Escapes a byte stream for use inside a quoted SQL literal. One request
// carries one raw byte plus a last marker; it yields zero to four escaped
// bytes, with out_last on the final escaped byte of a string. Result bytes
// leave at one per cycle from the output register of the back end while
// out_stall is low, so a byte that expands to two escaped bytes occupies
// the output for both and a held backslash resolved together with a
// following byte yields up to four; plain bytes run at one per cycle. The
// output byte rate is what limits throughput. A request is taken whenever
// the job queue (QUEUE_DEPTH entries) has room, even while results wait on
// out_stall; its result passes through the queue memory and then the
// output register of the back end. In LIKE mode a backslash that is not
// the last byte is held until the next byte, so it produces nothing on its
// own request. Mode registers sit at byte address 0 (quote doubling) and 4
// (LIKE pattern) and should only be written while the block is idle.
module sql_string_escaper #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	// output stream
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        out_last
);

	logic                quote_doubling_q;
	logic                like_pattern_q;
	logic                q_full;
	logic                q_empty;
	logic                push;
	logic                pop;
	sse_pkg::sse_entry_t push_entry;
	sse_pkg::sse_entry_t head;
	logic                wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// registers decoded by word index only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_doubling_q <= 1'b0;
			like_pattern_q   <= 1'b0;
		end else if (wr_en) begin
			if (paddr[2] == sse_pkg::REG_QUOTE_DOUBLING) quote_doubling_q <= pwdata[0];
			if (paddr[2] == sse_pkg::REG_LIKE_PATTERN)   like_pattern_q   <= pwdata[0];
		end
	end

	assign prdata = {31'd0,
		(paddr[2] == sse_pkg::REG_LIKE_PATTERN) ? like_pattern_q : quote_doubling_q};

	sse_front u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.in_byte             (in_byte),
		.in_last             (in_last),
		.quote_doubling_mode (quote_doubling_q),
		.like_pattern_mode   (like_pattern_q),
		.q_full              (q_full),
		.push                (push),
		.push_entry          (push_entry)
	);

	sse_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.empty      (q_empty)
	);

	sse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule
